// ===== rtl/greedy_bin_packing_assigner_unit_macros.svh =====
// Assertion macros for the greedy bin packing assigner.
// No dependencies; included by the top level only.
`ifndef GREEDY_BIN_PACKING_ASSIGNER_UNIT_MACROS_SVH
`define GREEDY_BIN_PACKING_ASSIGNER_UNIT_MACROS_SVH

// Same-cycle implication.
`define GBPA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GBPA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gbpa_pkg.sv =====
// Shared types and constants of the greedy bin packing assigner.
// No dependencies; imported by every module of the block but gbpa_ram.
package gbpa_pkg;

    localparam int ITEM_SIZE_WIDTH = 16;
    localparam int CFG_WIDTH       = 16;
    localparam int BIN_INDEX_WIDTH = 6;
    localparam int BINS_USED_WIDTH = 7;
    localparam int STATUS_WIDTH    = 2;

    localparam logic [31:0] CAP_RESET = 32'd6;

    localparam logic KIND_PLACE   = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STATUS_OVERSIZE = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STATUS_FULL     = 2'd2;

    typedef struct packed {
        logic                       kind;
        logic [ITEM_SIZE_WIDTH-1:0] item_size;
    } in_item_t;

    typedef struct packed {
        logic [BIN_INDEX_WIDTH-1:0] bin_index;
        logic                       opened_new;
        logic [BINS_USED_WIDTH-1:0] bins_used;
        logic [STATUS_WIDTH-1:0]    status;
    } res_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_NEWEST,
        ST_SCAN,
        ST_RESP
    } state_t;

    // Outcome of one placement, applied by the datapath.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_FIT_NEWEST,
        ACT_FIT_SCAN,
        ACT_OPEN,
        ACT_OVERSIZE,
        ACT_FULL
    } act_t;

    // Address source of the capacity memory read.
    typedef enum logic [1:0] {
        RD_NEWEST,
        RD_FIRST,
        RD_NEXT
    } rd_mode_t;

    typedef struct packed {
        logic     load_item;
        logic     restart;
        rd_mode_t rd_mode;
        logic     scan_step;
        act_t     act;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic oversize;
        logic empty;
        logic full;
        logic single;
        logic fits;
        logic scan_last;
    } dp_stat_t;

endpackage

// ===== rtl/greedy_bin_packing_assigner_unit.sv =====
// Greedy bin packing assigner, top level. A restart goes straight to the result; an item
// is checked for oversize, then tried in the newest bin, then in the earlier bins in order,
// one memory read per bin, before a new bin is opened. The next item is taken in the cycle
// the result register loads, so no new item is taken while one is in progress.
// Reset (aresetn low, synchronous) closes all bins and sets capacity to 6; no clearing
// pass, unopened bins are never read.
`include "greedy_bin_packing_assigner_unit_macros.svh"

module greedy_bin_packing_assigner_unit
    import gbpa_pkg::*;
#(
    parameter int MAX_BINS   = 64,
    parameter int SIZE_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // capacity register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    // item input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    // result output
    output logic                 m_valid,
    input  logic                 m_ready,
    output res_item_t            m_data
);

    cmd_t     cmd;
    dp_stat_t stat;

    // Capacity writes land at once; the user must write only while idle (not enforced here).
    assign cfg_ready = 1'b1;

    // Sequencer: evaluate, probe newest bin, stream earlier bins, hand over result.
    gbpa_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind (s_data.kind),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    // Capacity memory, bin count and result registers.
    gbpa_dp #(
        .MAX_BINS  (MAX_BINS),
        .SIZE_WIDTH(SIZE_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .in_data  (s_data),
        .cmd      (cmd),
        .stat     (stat),
        .m_data   (m_data)
    );

    // A placement occupies the block: no second transfer straight after it.
    `GBPA_ASSERT_NXT(a_place_busy, aclk, aresetn,
        s_valid && s_ready && (s_data.kind == KIND_PLACE), !s_ready,
        "input taken while a placement is in progress")

    // A pending result is never overwritten.
    `GBPA_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.out_load, !m_valid || m_ready,
        "result register loaded while holding an untaken result")

    // A newly opened bin is always the last one in use.
    `GBPA_ASSERT_IMP(a_open_is_last, aclk, aresetn, m_valid && m_data.opened_new,
        (m_data.status == STATUS_OK) &&
        (m_data.bin_index == 6'(m_data.bins_used - 7'd1)),
        "new bin index does not match bin count")

endmodule

// ===== rtl/gbpa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gbpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/gbpa_ctrl.sv =====
// Controller of the greedy bin packing assigner: sequencing FSM and output valid.
// Depends on gbpa_pkg.
module gbpa_ctrl
    import gbpa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_kind,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output cmd_t     cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    // Command decode
    always_comb begin
        cmd     = '0;
        cmd.rd_mode = RD_NEWEST;
        cmd.act     = ACT_NONE;
        s_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_EVAL: begin
                if (stat.oversize) begin
                    cmd.act = ACT_OVERSIZE;
                end else if (stat.empty) begin
                    cmd.act = ACT_OPEN;
                end
            end
            ST_NEWEST: begin
                cmd.rd_mode = RD_FIRST;
                if (stat.fits) begin
                    cmd.act = ACT_FIT_NEWEST;
                end else if (stat.single) begin
                    cmd.act = stat.full ? ACT_FULL : ACT_OPEN;
                end
            end
            ST_SCAN: begin
                cmd.rd_mode = RD_NEXT;
                if (stat.fits) begin
                    cmd.act = ACT_FIT_SCAN;
                end else if (stat.scan_last) begin
                    cmd.act = stat.full ? ACT_FULL : ACT_OPEN;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_RESP: begin
                cmd.out_load = out_free;
                s_ready      = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        cmd.load_item = accept && (s_kind == KIND_PLACE);
        cmd.restart   = accept && (s_kind == KIND_RESTART);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_kind == KIND_RESTART) ? ST_RESP : ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = (cmd.act != ACT_NONE) ? ST_RESP : ST_NEWEST;
            end
            ST_NEWEST: begin
                state_next = (cmd.act != ACT_NONE) ? ST_RESP : ST_SCAN;
            end
            ST_SCAN: begin
                if (cmd.act != ACT_NONE) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    if (accept) begin
                        state_next = (s_kind == KIND_RESTART) ? ST_RESP : ST_EVAL;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/gbpa_dp.sv =====
// Datapath of the greedy bin packing assigner: capacity memory, bin count,
// capacity register, compare/subtract and result registers.
// Depends on gbpa_pkg and gbpa_ram.
module gbpa_dp
    import gbpa_pkg::*;
#(
    parameter int MAX_BINS   = 64,
    parameter int SIZE_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    input  in_item_t             in_data,
    input  cmd_t                 cmd,
    output dp_stat_t             stat,
    output res_item_t            m_data
);

    localparam int AW = $clog2(MAX_BINS);
    localparam int CW = $clog2(MAX_BINS + 1);

    logic [SIZE_WIDTH-1:0] cap_reg, cap_next;
    logic [SIZE_WIDTH-1:0] size_reg, size_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         chk_reg, chk_next;

    logic [AW-1:0]           res_idx_reg, res_idx_next;
    logic                    res_opened_reg, res_opened_next;
    logic [STATUS_WIDTH-1:0] res_status_reg, res_status_next;
    res_item_t               m_data_reg, m_data_next;

    logic [31:0]           cfg_wide, item_wide, idx_wide, count_wide;
    logic [CW-1:0]         count_m1;
    logic [AW-1:0]         newest;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic [SIZE_WIDTH-1:0] wr_data, rd_data;

    assign cfg_wide  = 32'(cfg_data);
    assign item_wide = 32'(in_data.item_size);
    assign count_m1  = count_reg - CW'(1);
    assign newest    = count_m1[AW-1:0];

    gbpa_ram #(
        .WIDTH(SIZE_WIDTH),
        .DEPTH(MAX_BINS)
    ) u_cap_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb begin
        unique case (cmd.rd_mode)
            RD_NEWEST: rd_addr = newest;
            RD_FIRST:  rd_addr = '0;
            RD_NEXT:   rd_addr = chk_reg + AW'(1);
            default:   rd_addr = newest;
        endcase
    end

    always_comb begin
        stat.oversize  = size_reg > cap_reg;
        stat.empty     = count_reg == '0;
        stat.full      = count_reg == CW'(MAX_BINS);
        stat.single    = count_reg == CW'(1);
        stat.fits      = size_reg <= rd_data;
        stat.scan_last = ({1'b0, chk_reg} + (AW + 1)'(1)) == {1'b0, newest};
    end

    always_comb begin
        cap_next        = cfg_valid ? cfg_wide[SIZE_WIDTH-1:0] : cap_reg;
        size_next       = cmd.load_item ? item_wide[SIZE_WIDTH-1:0] : size_reg;
        count_next      = count_reg;
        chk_next        = chk_reg;
        res_idx_next    = res_idx_reg;
        res_opened_next = res_opened_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = newest;
        wr_data         = rd_data - size_reg;

        if (cmd.rd_mode == RD_FIRST) begin
            chk_next = '0;
        end else if (cmd.scan_step) begin
            chk_next = chk_reg + AW'(1);
        end

        unique case (cmd.act)
            ACT_NONE: begin
            end
            ACT_FIT_NEWEST: begin
                wr_en           = 1'b1;
                res_idx_next    = newest;
                res_opened_next = 1'b0;
                res_status_next = STATUS_OK;
            end
            ACT_FIT_SCAN: begin
                wr_en           = 1'b1;
                wr_addr         = chk_reg;
                res_idx_next    = chk_reg;
                res_opened_next = 1'b0;
                res_status_next = STATUS_OK;
            end
            ACT_OPEN: begin
                wr_en           = 1'b1;
                wr_addr         = count_reg[AW-1:0];
                wr_data         = cap_reg - size_reg;
                count_next      = count_reg + CW'(1);
                res_idx_next    = count_reg[AW-1:0];
                res_opened_next = 1'b1;
                res_status_next = STATUS_OK;
            end
            ACT_OVERSIZE: begin
                res_idx_next    = '0;
                res_opened_next = 1'b0;
                res_status_next = STATUS_OVERSIZE;
            end
            ACT_FULL: begin
                res_idx_next    = '0;
                res_opened_next = 1'b0;
                res_status_next = STATUS_FULL;
            end
            default: begin
            end
        endcase

        if (cmd.restart) begin
            count_next      = '0;
            res_idx_next    = '0;
            res_opened_next = 1'b0;
            res_status_next = STATUS_OK;
        end
    end

    // Result register; bins_used is the count after the step.
    assign idx_wide   = 32'(res_idx_reg);
    assign count_wide = 32'(count_reg);

    always_comb begin
        m_data_next = m_data_reg;
        if (cmd.out_load) begin
            m_data_next.bin_index  = idx_wide[BIN_INDEX_WIDTH-1:0];
            m_data_next.opened_new = res_opened_reg;
            m_data_next.bins_used  = count_wide[BINS_USED_WIDTH-1:0];
            m_data_next.status     = res_status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CAP_RESET[SIZE_WIDTH-1:0];
            count_reg <= '0;
        end else begin
            cap_reg   <= cap_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg       <= size_next;
        chk_reg        <= chk_next;
        res_idx_reg    <= res_idx_next;
        res_opened_reg <= res_opened_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    assign m_data = m_data_reg;

endmodule
